[sv/fatseq_pkg.sv]
// Shared types and constants for the FAT16 cluster chain sector sequencer.
`default_nettype none
package fatseq_pkg;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);

  localparam logic [15:0] EOC_MARK = 16'hFFF8;
  localparam logic [15:0] FIRST_DATA_CLUSTER = 16'd2;
  localparam logic [6:0] SPC_MAX = 7'd64;
  localparam logic [6:0] SPC_MIN = 7'd1;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_REPLY = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    REG_FAT_START = 2'd0,
    REG_DATA_START = 2'd1,
    REG_SPC = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_SECTOR = 2'd0,
    KIND_SECTOR_FAT = 2'd1,
    KIND_SECTOR_DONE = 2'd2,
    KIND_FINISHED = 2'd3
  } result_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic emit_sector;
    logic emit_empty;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_start;
    logic start_empty;
    logic reply_eoc;
    logic awaiting;
    logic out_free;
    logic emit_last;
  } dp_status_t;

endpackage
`default_nettype wire

[sv/fatseq_ctrl.sv]
// Controller state machine that sequences request intake, setup and result emission.
`default_nettype none
module fatseq_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire fatseq_pkg::dp_status_t status,
  output fatseq_pkg::ctrl_cmd_t       cmd
);
  import fatseq_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (status.is_start) begin
            state_next = status.start_empty ? ST_EMPTY : ST_SETUP;
          end else if (status.awaiting) begin
            state_next = status.reply_eoc ? ST_EMPTY : ST_SETUP;
          end
        end
      end
      ST_SETUP: state_next = ST_RUN;
      ST_RUN: begin
        if (status.out_free && status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SETUP: cmd.setup = 1'b1;
      ST_RUN: cmd.emit_sector = status.out_free;
      ST_EMPTY: cmd.emit_empty = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[sv/fatseq_dp.sv]
// Datapath with configuration registers, read state, sector arithmetic and output register.
`default_nettype none
module fatseq_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [31:0]           cfg_data,
  input  wire logic                  command,
  input  wire logic [15:0]           start_cluster,
  input  wire logic [31:0]           file_length,
  input  wire logic [30:0]           request_bytes,
  input  wire logic [15:0]           fat_entry,
  input  wire fatseq_pkg::ctrl_cmd_t cmd,
  output fatseq_pkg::dp_status_t     status,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 result_kind,
  output logic [31:0]                sector_address,
  output logic [9:0]                 sector_bytes,
  output logic [31:0]                fat_sector_address,
  output logic [8:0]                 fat_byte_offset,
  output logic [30:0]                total_read,
  output logic                       last
);
  import fatseq_pkg::*;

  logic [31:0] fat_start;
  logic [31:0] data_start;
  logic [6:0]  spc;
  logic [30:0] target;
  logic [30:0] done;
  logic [15:0] cluster;
  logic        awaiting;
  logic [31:0] first;
  logic [5:0]  idx;

  logic [30:0] target_in;
  logic [6:0]  spc_in;
  logic [31:0] cluster_rel;
  logic [31:0] first_next;
  logic [30:0] left;
  logic [30:0] take;
  logic [30:0] done_next;
  logic        fin;
  logic        end_cluster;
  logic [16:0] fat_off;
  logic [31:0] fat_sector;

  assign target_in = ({1'b0, request_bytes} < file_length) ? request_bytes : file_length[30:0];
  assign spc_in = (cfg_data[6:0] == 7'd0) ? SPC_MIN :
                  (cfg_data[6:0] > SPC_MAX) ? SPC_MAX : cfg_data[6:0];

  assign cluster_rel = {16'd0, cluster} - {16'd0, FIRST_DATA_CLUSTER};
  assign first_next = data_start + 32'(cluster_rel * {25'd0, spc});

  assign left = target - done;
  assign take = (left < 31'(SECTOR_BYTES)) ? left : 31'(SECTOR_BYTES);
  assign done_next = done + take;
  assign fin = (done_next >= target);
  assign end_cluster = ({1'b0, idx} + 7'd1) == spc;
  assign fat_off = {cluster, 1'b0};
  assign fat_sector = fat_start + 32'(fat_off >> SECTOR_SHIFT);

  assign status.is_start = (command == CMD_START);
  assign status.start_empty = (target_in == 31'd0) || (start_cluster < FIRST_DATA_CLUSTER) ||
                              (start_cluster >= EOC_MARK);
  assign status.reply_eoc = (fat_entry >= EOC_MARK);
  assign status.awaiting = awaiting;
  assign status.out_free = !out_valid || out_ready;
  assign status.emit_last = fin || end_cluster;

  always_ff @(posedge clk) begin
    if (rst) begin
      fat_start <= '0;
      data_start <= '0;
      spc <= SPC_MIN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FAT_START: fat_start <= cfg_data;
        REG_DATA_START: data_start <= cfg_data;
        REG_SPC: spc <= spc_in;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
      done <= '0;
      cluster <= '0;
      awaiting <= 1'b0;
    end else if (cmd.accept) begin
      if (command == CMD_START) begin
        target <= target_in;
        done <= '0;
        cluster <= start_cluster;
        awaiting <= 1'b0;
      end else if (awaiting) begin
        cluster <= fat_entry;
        awaiting <= 1'b0;
      end
    end else if (cmd.emit_sector) begin
      done <= done_next;
      if (!fin && end_cluster) begin
        awaiting <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      first <= first_next;
      idx <= '0;
    end else if (cmd.emit_sector) begin
      idx <= idx + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sector || cmd.emit_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_empty) begin
      result_kind <= KIND_FINISHED;
      sector_address <= '0;
      sector_bytes <= '0;
      fat_sector_address <= '0;
      fat_byte_offset <= '0;
      total_read <= done;
      last <= 1'b1;
    end else if (cmd.emit_sector) begin
      sector_address <= first + {26'd0, idx};
      sector_bytes <= take[9:0];
      total_read <= done_next;
      last <= fin || end_cluster;
      if (fin) begin
        result_kind <= KIND_SECTOR_DONE;
        fat_sector_address <= '0;
        fat_byte_offset <= '0;
      end else if (end_cluster) begin
        result_kind <= KIND_SECTOR_FAT;
        fat_sector_address <= fat_sector;
        fat_byte_offset <= fat_off[8:0];
      end else begin
        result_kind <= KIND_SECTOR;
        fat_sector_address <= '0;
        fat_byte_offset <= '0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sector || cmd.emit_empty) && out_valid |-> out_ready)
    else $error("result register overwritten while a request was pending");

  a_single_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_sector && cmd.emit_empty))
    else $error("sector and empty results loaded together");

  a_fat_then_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_sector && !fin && end_cluster |=> awaiting && out_valid && last)
    else $error("FAT lookup result without waiting for a reply");

  a_kind_fat_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_SECTOR_FAT || result_kind == KIND_FINISHED) |-> last)
    else $error("lookup or finished result not marked last");

endmodule
`default_nettype wire

[sv/fat16_cluster_chain_sector_sequencer.sv]
// Top level of the FAT16 cluster chain sector sequencer.
//
// Channel  Signals                                   Direction
// cfg      cfg_valid cfg_ready cfg_index cfg_data    in (cfg_ready always high)
// in       in_valid in_ready command ... fat_entry   in
// out      out_valid out_ready result_kind ... last  out
//
// A start or reply request is accepted in the idle state; a finished-without-sector result
// is then loaded from the empty state, otherwise a setup state computes the cluster's first sector.
// Sector results then leave at one per cycle while out_ready is high, up to
// sectors_per_cluster of them; the single sector adder and compare set that pace.
// A stall on out_ready holds the output register and the sequence; new requests are
// taken only once the last result of a run is loaded. Reset is synchronous.
`default_nettype none
module fat16_cluster_chain_sector_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [15:0] start_cluster,
  input  wire logic [31:0] file_length,
  input  wire logic [30:0] request_bytes,
  input  wire logic [15:0] fat_entry,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       result_kind,
  output logic [31:0]      sector_address,
  output logic [9:0]       sector_bytes,
  output logic [31:0]      fat_sector_address,
  output logic [8:0]       fat_byte_offset,
  output logic [30:0]      total_read,
  output logic             last
);
  import fatseq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  fatseq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fatseq_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .command            (command),
    .start_cluster      (start_cluster),
    .file_length        (file_length),
    .request_bytes      (request_bytes),
    .fat_entry          (fat_entry),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .result_kind        (result_kind),
    .sector_address     (sector_address),
    .sector_bytes       (sector_bytes),
    .fat_sector_address (fat_sector_address),
    .fat_byte_offset    (fat_byte_offset),
    .total_read         (total_read),
    .last               (last)
  );

endmodule
`default_nettype wire
